FILE: hdl/assert_macros.svh
// Assertion macros; clk and rst_n are taken from the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RVS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rvs check failed");

// next-cycle implication
`define RVS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rvs check failed");

`endif

FILE: hdl/rvs_pkg.sv
package rvs_pkg;

    localparam int RATE_W     = 32;
    localparam int DIM_W      = 15;
    localparam int AREA_W     = 2 * DIM_W;
    localparam int ROOT_W     = 16;
    localparam int SCORE_W    = 29;
    localparam int INDEX_W    = 6;
    localparam int HOW_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // divide by ten, one quotient bit a cycle
    localparam int DIV_W      = RATE_W + 4;
    localparam int DIV_STEPS  = DIV_W;
    localparam int DIVISOR    = 10;
    localparam int DIV_REM_W  = 4;

    localparam int SQRT_STEPS = ROOT_W;
    localparam int SQRT_REM_W = ROOT_W + 1;
    localparam int MULT_STEPS = DIM_W;

    localparam logic [SCORE_W-1:0] SCORE_MAX    = {SCORE_W{1'b1}};
    localparam logic [DIM_W-1:0]   SCREEN_RESET = 15'd16384;

    localparam logic [HOW_W-1:0] HOW_BEST     = 2'd0;
    localparam logic [HOW_W-1:0] HOW_FALLBACK = 2'd1;
    localparam logic [HOW_W-1:0] HOW_NONE     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_FLOOR    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_CEILING  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_DIV,
        ST_CALC_START,
        ST_CALC,
        ST_DIFF,
        ST_SCORE,
        ST_UPDATE,
        ST_REPORT
    } state_t;

endpackage

FILE: hdl/rate_variant_selector_unit.sv
// channel  | handshake             | words carry
// input    | in_valid / in_ready   | estimate apply_limits is_video present variant_width
//          |                       | variant_height variant_rate last_in_set
// result   | out_valid / out_ready | chosen_index chosen_rate how_chosen
// config   | cfg_we                | cfg_index cfg_data
//
// The time from a word's acceptance to the next in_ready is set by the
// 16-step bit-serial square root (the 15-step serial multipliers run beside it).
// The first word of a set with limits on also waits for the serial divide by ten.
// A last word adds a report step, held while the result register is still full.
// rst_n is asynchronous, active low; it clears the set and restores the registers.
module rate_variant_selector_unit
#(
    parameter int MAX_VARIANTS = 64
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [rvs_pkg::RATE_W-1:0]          estimate,
    input  logic                                apply_limits,
    input  logic                                is_video,
    input  logic                                present,
    input  logic [rvs_pkg::DIM_W-1:0]           variant_width,
    input  logic [rvs_pkg::DIM_W-1:0]           variant_height,
    input  logic [rvs_pkg::RATE_W-1:0]          variant_rate,
    input  logic                                last_in_set,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [rvs_pkg::INDEX_W-1:0]         chosen_index,
    output logic [rvs_pkg::RATE_W-1:0]          chosen_rate,
    output logic [rvs_pkg::HOW_W-1:0]           how_chosen,
    input  logic                                cfg_we,
    input  logic [rvs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rvs_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int POS_W = $clog2(MAX_VARIANTS + 1);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_VARIANTS);

    rvs_pkg::state_t state_reg, state_next;

    logic [rvs_pkg::DIM_W-1:0]  screen_w_reg, screen_h_reg;
    logic [rvs_pkg::RATE_W-1:0] rate_floor_reg, rate_ceiling_reg;

    logic [POS_W-1:0]            pos_reg, pos_next;
    logic [rvs_pkg::RATE_W-1:0]  budget_reg, budget_next;
    logic [rvs_pkg::SCORE_W-1:0] best_score_reg, best_score_next;
    logic [POS_W-1:0]            best_pos_reg, best_pos_next;
    logic [rvs_pkg::RATE_W-1:0]  best_rate_reg, best_rate_next;
    logic                        best_valid_reg, best_valid_next;
    logic [rvs_pkg::RATE_W-1:0]  low_rate_reg, low_rate_next;
    logic [POS_W-1:0]            low_pos_reg, low_pos_next;
    logic                        low_valid_reg, low_valid_next;

    logic                        video_reg, video_next;
    logic                        cand_reg, cand_next;
    logic                        last_reg, last_next;
    logic [rvs_pkg::DIM_W-1:0]   vw_reg, vw_next, vh_reg, vh_next;
    logic [rvs_pkg::RATE_W-1:0]  vrate_reg, vrate_next;
    logic [rvs_pkg::AREA_W-1:0]  diff_reg, diff_next;
    logic [rvs_pkg::SCORE_W-1:0] score_reg, score_next;

    logic                        out_valid_reg, out_valid_next;
    logic [rvs_pkg::INDEX_W-1:0] out_index_reg, out_index_next;
    logic [rvs_pkg::RATE_W-1:0]  out_rate_reg, out_rate_next;
    logic [rvs_pkg::HOW_W-1:0]   out_how_reg, out_how_next;

    logic [rvs_pkg::RATE_W-1:0]  clamp_lo, clamp_hi;
    logic [rvs_pkg::DIV_W-1:0]   budget_wide, scale_dividend;
    logic [rvs_pkg::AREA_W:0]    score_sum;
    logic                        div_start, calc_start;
    logic                        div_done, sqrt_done, mv_done, ms_done;
    logic [rvs_pkg::RATE_W-1:0]  div_quot;
    logic [rvs_pkg::ROOT_W-1:0]  sqrt_root;
    logic [rvs_pkg::AREA_W-1:0]  area_variant, area_screen;
    logic                        accept, out_free;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = state_reg == rvs_pkg::ST_IDLE;

    assign clamp_lo = (rate_floor_reg != '0 && estimate < rate_floor_reg)
                    ? rate_floor_reg : estimate;
    assign clamp_hi = (rate_ceiling_reg != '0 && clamp_lo > rate_ceiling_reg)
                    ? rate_ceiling_reg : clamp_lo;

    assign budget_wide    = rvs_pkg::DIV_W'(budget_reg);
    assign scale_dividend = video_reg ? (budget_wide << 3) + budget_wide : budget_wide;
    assign score_sum      = {1'b0, diff_reg} + rvs_pkg::AREA_W'(sqrt_root) + '0;

    rvs_div10 u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (scale_dividend),
        .quotient (div_quot),
        .done     (div_done)
    );

    rvs_serial_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (calc_start),
        .radicand (budget_reg - vrate_reg),
        .root     (sqrt_root),
        .done     (sqrt_done)
    );

    rvs_serial_mult u_mult_variant
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (calc_start),
        .multiplicand (vw_reg),
        .multiplier   (vh_reg),
        .product      (area_variant),
        .done         (mv_done)
    );

    rvs_serial_mult u_mult_screen
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (calc_start),
        .multiplicand (screen_w_reg),
        .multiplier   (screen_h_reg),
        .product      (area_screen),
        .done         (ms_done)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_w_reg     <= rvs_pkg::SCREEN_RESET;
            screen_h_reg     <= rvs_pkg::SCREEN_RESET;
            rate_floor_reg   <= '0;
            rate_ceiling_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rvs_pkg::CFG_SCREEN_WIDTH:  screen_w_reg     <= cfg_data[rvs_pkg::DIM_W-1:0];
                rvs_pkg::CFG_SCREEN_HEIGHT: screen_h_reg     <= cfg_data[rvs_pkg::DIM_W-1:0];
                rvs_pkg::CFG_RATE_FLOOR:    rate_floor_reg   <= cfg_data;
                rvs_pkg::CFG_RATE_CEILING:  rate_ceiling_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rvs_pkg::ST_IDLE;
            pos_reg        <= '0;
            budget_reg     <= '0;
            best_score_reg <= '0;
            best_pos_reg   <= '0;
            best_rate_reg  <= '0;
            best_valid_reg <= 1'b0;
            low_rate_reg   <= '0;
            low_pos_reg    <= '0;
            low_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            budget_reg     <= budget_next;
            best_score_reg <= best_score_next;
            best_pos_reg   <= best_pos_next;
            best_rate_reg  <= best_rate_next;
            best_valid_reg <= best_valid_next;
            low_rate_reg   <= low_rate_next;
            low_pos_reg    <= low_pos_next;
            low_valid_reg  <= low_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        video_reg     <= video_next;
        cand_reg      <= cand_next;
        last_reg      <= last_next;
        vw_reg        <= vw_next;
        vh_reg        <= vh_next;
        vrate_reg     <= vrate_next;
        diff_reg      <= diff_next;
        score_reg     <= score_next;
        out_index_reg <= out_index_next;
        out_rate_reg  <= out_rate_next;
        out_how_reg   <= out_how_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        budget_next     = budget_reg;
        best_score_next = best_score_reg;
        best_pos_next   = best_pos_reg;
        best_rate_next  = best_rate_reg;
        best_valid_next = best_valid_reg;
        low_rate_next   = low_rate_reg;
        low_pos_next    = low_pos_reg;
        low_valid_next  = low_valid_reg;
        video_next      = video_reg;
        cand_next       = cand_reg;
        last_next       = last_reg;
        vw_next         = vw_reg;
        vh_next         = vh_reg;
        vrate_next      = vrate_reg;
        diff_next       = diff_reg;
        score_next      = score_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_index_next  = out_index_reg;
        out_rate_next   = out_rate_reg;
        out_how_next    = out_how_reg;
        div_start       = 1'b0;
        calc_start      = 1'b0;

        case (state_reg)
            rvs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    video_next = is_video;
                    cand_next  = present && (pos_reg < POS_LIMIT);
                    last_next  = last_in_set;
                    vw_next    = variant_width;
                    vh_next    = variant_height;
                    vrate_next = variant_rate;
                    state_next = rvs_pkg::ST_CALC_START;
                    if (pos_reg == '0)
                    begin
                        budget_next = apply_limits ? clamp_hi : estimate;
                        if (apply_limits)
                        begin
                            state_next = rvs_pkg::ST_SCALE;
                        end
                    end
                end
            end
            rvs_pkg::ST_SCALE:
            begin
                div_start  = 1'b1;
                state_next = rvs_pkg::ST_DIV;
            end
            rvs_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    budget_next = div_quot;
                    state_next  = rvs_pkg::ST_CALC_START;
                end
            end
            rvs_pkg::ST_CALC_START:
            begin
                calc_start = 1'b1;
                state_next = rvs_pkg::ST_CALC;
            end
            rvs_pkg::ST_CALC:
            begin
                if (sqrt_done && mv_done && ms_done)
                begin
                    state_next = rvs_pkg::ST_DIFF;
                end
            end
            rvs_pkg::ST_DIFF:
            begin
                diff_next  = (area_variant >= area_screen) ? area_variant - area_screen
                                                           : area_screen - area_variant;
                state_next = rvs_pkg::ST_SCORE;
            end
            rvs_pkg::ST_SCORE:
            begin
                score_next = (score_sum > (rvs_pkg::AREA_W+1)'(rvs_pkg::SCORE_MAX))
                           ? rvs_pkg::SCORE_MAX : score_sum[rvs_pkg::SCORE_W-1:0];
                state_next = rvs_pkg::ST_UPDATE;
            end
            rvs_pkg::ST_UPDATE:
            begin
                if (cand_reg)
                begin
                    if (!low_valid_reg || vrate_reg < low_rate_reg)
                    begin
                        low_valid_next = 1'b1;
                        low_rate_next  = vrate_reg;
                        low_pos_next   = pos_reg;
                    end
                    if (vrate_reg <= budget_reg
                        && (!best_valid_reg || score_reg < best_score_reg))
                    begin
                        best_valid_next = 1'b1;
                        best_score_next = score_reg;
                        best_pos_next   = pos_reg;
                        best_rate_next  = vrate_reg;
                    end
                end
                if (pos_reg < POS_LIMIT)
                begin
                    pos_next = pos_reg + 1'b1;
                end
                state_next = last_reg ? rvs_pkg::ST_REPORT : rvs_pkg::ST_IDLE;
            end
            rvs_pkg::ST_REPORT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (best_valid_reg)
                    begin
                        out_index_next = rvs_pkg::INDEX_W'(best_pos_reg);
                        out_rate_next  = best_rate_reg;
                        out_how_next   = rvs_pkg::HOW_BEST;
                    end
                    else if (low_valid_reg)
                    begin
                        out_index_next = rvs_pkg::INDEX_W'(low_pos_reg);
                        out_rate_next  = low_rate_reg;
                        out_how_next   = rvs_pkg::HOW_FALLBACK;
                    end
                    else
                    begin
                        out_index_next = '0;
                        out_rate_next  = '0;
                        out_how_next   = rvs_pkg::HOW_NONE;
                    end
                    pos_next        = '0;
                    budget_next     = '0;
                    best_score_next = '0;
                    best_pos_next   = '0;
                    best_rate_next  = '0;
                    best_valid_next = 1'b0;
                    low_rate_next   = '0;
                    low_pos_next    = '0;
                    low_valid_next  = 1'b0;
                    state_next      = rvs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rvs_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign chosen_index = out_index_reg;
    assign chosen_rate  = out_rate_reg;
    assign how_chosen   = out_how_reg;

endmodule

FILE: hdl/rvs_serial_mult.sv
module rvs_serial_mult
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rvs_pkg::DIM_W-1:0]   multiplicand,
    input  logic [rvs_pkg::DIM_W-1:0]   multiplier,
    output logic [rvs_pkg::AREA_W-1:0]  product,
    output logic                        done
);

    localparam int CNT_W = $clog2(rvs_pkg::MULT_STEPS);

    logic [rvs_pkg::AREA_W-1:0] prod_reg, prod_next;
    logic [rvs_pkg::DIM_W-1:0]  mcand_reg, mcand_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [rvs_pkg::DIM_W:0]    upper;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        mcand_reg <= mcand_next;
    end

    // shift-add, one multiplier bit a cycle
    always_comb
    begin
        upper      = {1'b0, prod_reg[rvs_pkg::AREA_W-1:rvs_pkg::DIM_W]}
                   + (prod_reg[0] ? {1'b0, mcand_reg} : '0);
        prod_next  = prod_reg;
        mcand_next = mcand_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = done_reg;
        if (start)
        begin
            prod_next  = {{rvs_pkg::DIM_W{1'b0}}, multiplier};
            mcand_next = multiplicand;
            count_next = CNT_W'(rvs_pkg::MULT_STEPS - 1);
            busy_next  = 1'b1;
            done_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            prod_next  = {upper, prod_reg[rvs_pkg::DIM_W-1:1]};
            count_next = count_reg - 1'b1;
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign product = prod_reg;
    assign done    = done_reg;

endmodule

FILE: hdl/rvs_serial_sqrt.sv
module rvs_serial_sqrt
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rvs_pkg::RATE_W-1:0]  radicand,
    output logic [rvs_pkg::ROOT_W-1:0]  root,
    output logic                        done
);

    localparam int CNT_W = $clog2(rvs_pkg::SQRT_STEPS);
    localparam int TRY_W = rvs_pkg::ROOT_W + 3;

    logic [rvs_pkg::RATE_W-1:0]     rad_reg, rad_next;
    logic [rvs_pkg::SQRT_REM_W-1:0] rem_reg, rem_next;
    logic [rvs_pkg::ROOT_W-1:0]     root_reg, root_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [TRY_W-1:0]               trial_rem;
    logic [TRY_W-1:0]               trial;
    logic                           fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    // restoring root, two radicand bits a cycle
    always_comb
    begin
        trial_rem  = {rem_reg, rad_reg[rvs_pkg::RATE_W-1 -: 2]};
        trial      = {1'b0, root_reg, 2'b01};
        fits       = trial_rem >= trial;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = done_reg;
        if (start)
        begin
            rad_next   = radicand;
            rem_next   = '0;
            root_next  = '0;
            count_next = CNT_W'(rvs_pkg::SQRT_STEPS - 1);
            busy_next  = 1'b1;
            done_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            rad_next   = {rad_reg[rvs_pkg::RATE_W-3:0], 2'b00};
            rem_next   = fits ? rvs_pkg::SQRT_REM_W'(trial_rem - trial)
                              : trial_rem[rvs_pkg::SQRT_REM_W-1:0];
            root_next  = {root_reg[rvs_pkg::ROOT_W-2:0], fits};
            count_next = count_reg - 1'b1;
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

FILE: hdl/rvs_div10.sv
module rvs_div10
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rvs_pkg::DIV_W-1:0]   dividend,
    output logic [rvs_pkg::RATE_W-1:0]  quotient,
    output logic                        done
);

    localparam int CNT_W = $clog2(rvs_pkg::DIV_STEPS);
    localparam int TRY_W = rvs_pkg::DIV_REM_W + 1;

    logic [rvs_pkg::DIV_W-1:0]     shift_reg, shift_next;
    logic [rvs_pkg::DIV_REM_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [TRY_W-1:0]              trial;
    logic                          fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    // dividend leaves at the top, quotient bits enter at the bottom
    always_comb
    begin
        trial      = {rem_reg, shift_reg[rvs_pkg::DIV_W-1]};
        fits       = trial >= TRY_W'(rvs_pkg::DIVISOR);
        shift_next = shift_reg;
        rem_next   = rem_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = done_reg;
        if (start)
        begin
            shift_next = dividend;
            rem_next   = '0;
            count_next = CNT_W'(rvs_pkg::DIV_STEPS - 1);
            busy_next  = 1'b1;
            done_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[rvs_pkg::DIV_W-2:0], fits};
            rem_next   = fits ? rvs_pkg::DIV_REM_W'(trial - TRY_W'(rvs_pkg::DIVISOR))
                              : trial[rvs_pkg::DIV_REM_W-1:0];
            count_next = count_reg - 1'b1;
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign quotient = shift_reg[rvs_pkg::RATE_W-1:0];
    assign done     = done_reg;

endmodule

FILE: hdl/rvs_checker.sv
`include "assert_macros.svh"

module rvs_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [rvs_pkg::INDEX_W-1:0] chosen_index,
    input  logic [rvs_pkg::RATE_W-1:0]  chosen_rate,
    input  logic [rvs_pkg::HOW_W-1:0]   how_chosen
);

    // a waiting result stays
    `RVS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)

    // one word at a time: ready drops after each accepted word
    `RVS_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

    // a fresh result only comes out of the report step, never from idle
    `RVS_ASSERT_IMP(a_result_from_report, $rose(out_valid), $past(!in_ready))

    // empty set reports zeros
    `RVS_ASSERT_IMP(a_none_is_zero, out_valid && how_chosen == rvs_pkg::HOW_NONE,
        chosen_index == '0 && chosen_rate == '0)

endmodule

bind rate_variant_selector_unit rvs_checker u_rvs_checker (.*);

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int VARIANT_SLOTS = 64;
    localparam int PHASE_WORDS   = 85;

    typedef struct packed {
        logic [rvs_pkg::RATE_W-1:0] estimate;
        logic                       apply_limits;
        logic                       is_video;
        logic                       present;
        logic [rvs_pkg::DIM_W-1:0]  variant_width;
        logic [rvs_pkg::DIM_W-1:0]  variant_height;
        logic [rvs_pkg::RATE_W-1:0] variant_rate;
        logic                       last_in_set;
    } word_t;

    typedef struct packed {
        logic [rvs_pkg::INDEX_W-1:0] index;
        logic [rvs_pkg::RATE_W-1:0]  rate;
        logic [rvs_pkg::HOW_W-1:0]   how;
    } choice_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [rvs_pkg::RATE_W-1:0]     estimate = '0;
    logic                           apply_limits = 1'b0;
    logic                           is_video = 1'b0;
    logic                           present = 1'b0;
    logic [rvs_pkg::DIM_W-1:0]      variant_width = '0;
    logic [rvs_pkg::DIM_W-1:0]      variant_height = '0;
    logic [rvs_pkg::RATE_W-1:0]     variant_rate = '0;
    logic                           last_in_set = 1'b0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [rvs_pkg::INDEX_W-1:0]    chosen_index;
    logic [rvs_pkg::RATE_W-1:0]     chosen_rate;
    logic [rvs_pkg::HOW_W-1:0]      how_chosen;
    logic                           cfg_we = 1'b0;
    logic [rvs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [rvs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    rate_variant_selector_unit #(
        .MAX_VARIANTS (VARIANT_SLOTS)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .estimate       (estimate),
        .apply_limits   (apply_limits),
        .is_video       (is_video),
        .present        (present),
        .variant_width  (variant_width),
        .variant_height (variant_height),
        .variant_rate   (variant_rate),
        .last_in_set    (last_in_set),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .chosen_index   (chosen_index),
        .chosen_rate    (chosen_rate),
        .how_chosen     (how_chosen),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // register copies and selection state of the predictor
    logic [rvs_pkg::DIM_W-1:0]   scr_w = rvs_pkg::SCREEN_RESET;
    logic [rvs_pkg::DIM_W-1:0]   scr_h = rvs_pkg::SCREEN_RESET;
    logic [rvs_pkg::RATE_W-1:0]  floor_bps = '0;
    logic [rvs_pkg::RATE_W-1:0]  ceil_bps = '0;
    int                          set_pos = 0;
    logic [rvs_pkg::RATE_W-1:0]  set_budget = '0;
    logic [rvs_pkg::SCORE_W-1:0] top_score = '0;
    logic [rvs_pkg::INDEX_W-1:0] top_pos = '0;
    logic [rvs_pkg::RATE_W-1:0]  top_rate = '0;
    bit                          top_found = 1'b0;
    logic [rvs_pkg::RATE_W-1:0]  low_rate = '0;
    logic [rvs_pkg::INDEX_W-1:0] low_pos = '0;
    bit                          low_found = 1'b0;

    word_t   pending_words[$];
    choice_t awaited_choices[$];

    int words_total = 0;
    int sets_total = 0;
    int long_sets = 0;
    int settings_used = 1;
    int fails = 0;
    int by_score = 0;
    int by_lowest = 0;
    int by_none = 0;

    function automatic logic [rvs_pkg::ROOT_W-1:0] root_floor(
        input logic [rvs_pkg::RATE_W-1:0] v);
        logic [rvs_pkg::ROOT_W-1:0] r;
        logic [rvs_pkg::ROOT_W-1:0] cand;
        logic [rvs_pkg::RATE_W-1:0] sq;
        r = '0;
        for (int b = rvs_pkg::ROOT_W - 1; b >= 0; b--)
        begin
            cand = r | (rvs_pkg::ROOT_W'(1) << b);
            sq = cand * cand;
            if (sq <= v)
                r = cand;
        end
        return r;
    endfunction

    function automatic bit pick_variant(input word_t w, output choice_t c);
        logic [63:0] b;
        logic [63:0] area;
        logic [63:0] screen;
        logic [63:0] diff;
        logic [63:0] score;
        c = '0;
        if (set_pos == 0)
        begin
            b = 64'(w.estimate);
            if (w.apply_limits)
            begin
                if (floor_bps != 0 && b < 64'(floor_bps))
                    b = 64'(floor_bps);
                if (ceil_bps != 0 && b > 64'(ceil_bps))
                    b = 64'(ceil_bps);
                b = w.is_video ? (b * 9) / 10 : b / 10;
            end
            set_budget = b[rvs_pkg::RATE_W-1:0];
        end
        if (w.present && set_pos < VARIANT_SLOTS)
        begin
            if (!low_found || w.variant_rate < low_rate)
            begin
                low_found = 1'b1;
                low_rate = w.variant_rate;
                low_pos = set_pos[rvs_pkg::INDEX_W-1:0];
            end
            if (w.variant_rate <= set_budget)
            begin
                area = 64'(w.variant_width) * 64'(w.variant_height);
                screen = 64'(scr_w) * 64'(scr_h);
                diff = (area >= screen) ? area - screen : screen - area;
                score = diff + 64'(root_floor(set_budget - w.variant_rate));
                if (score > 64'(rvs_pkg::SCORE_MAX))
                    score = 64'(rvs_pkg::SCORE_MAX);
                if (!top_found || score[rvs_pkg::SCORE_W-1:0] < top_score)
                begin
                    top_found = 1'b1;
                    top_score = score[rvs_pkg::SCORE_W-1:0];
                    top_pos = set_pos[rvs_pkg::INDEX_W-1:0];
                    top_rate = w.variant_rate;
                end
            end
        end
        if (set_pos < VARIANT_SLOTS)
            set_pos++;
        if (!w.last_in_set)
            return 1'b0;
        if (top_found)
            c = '{index: top_pos, rate: top_rate, how: rvs_pkg::HOW_BEST};
        else if (low_found)
            c = '{index: low_pos, rate: low_rate, how: rvs_pkg::HOW_FALLBACK};
        else
            c = '{index: '0, rate: '0, how: rvs_pkg::HOW_NONE};
        set_pos = 0;
        set_budget = '0;
        top_score = '0;
        top_pos = '0;
        top_rate = '0;
        top_found = 1'b0;
        low_rate = '0;
        low_pos = '0;
        low_found = 1'b0;
        return 1'b1;
    endfunction

    // sender: bursts of words with random gaps
    word_t   on_offer;
    choice_t outcome;
    bit      taken;
    int      burst_left = 0;
    int      gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            taken = in_valid && in_ready;
            if (taken && pick_variant(on_offer, outcome))
                awaited_choices = {awaited_choices, outcome};
            if (!in_valid || taken)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    on_offer = pending_words[0];
                    pending_words.delete(0);
                    estimate <= on_offer.estimate;
                    apply_limits <= on_offer.apply_limits;
                    is_video <= on_offer.is_video;
                    present <= on_offer.present;
                    variant_width <= on_offer.variant_width;
                    variant_height <= on_offer.variant_height;
                    variant_rate <= on_offer.variant_rate;
                    last_in_set <= on_offer.last_in_set;
                    in_valid <= 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: changing stall pattern, two long hold-offs
    int          rx_cyc = 0;
    int          rx_mode = 0;
    logic [31:0] ready_mask = '1;
    int          handed = 0;
    int          hold_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            rx_cyc++;
            if (rx_cyc % 256 == 0)
            begin
                rx_mode = $urandom_range(0, 2);
                ready_mask = $urandom;
            end
            if (out_valid && out_ready)
            begin
                handed++;
                if (handed == 25 || handed == 110)
                    hold_left = 600;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (rx_mode == 0)
                out_ready <= 1'b1;
            else if (rx_mode == 1)
                out_ready <= ready_mask[rx_cyc % 32];
            else
                out_ready <= ($urandom_range(0, 2) != 0);
        end
    end

    choice_t due;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_choices.size() == 0)
            begin
                $display("%0t: unexpected word: expected none, got index %0d rate %0d how %0d",
                         $time, chosen_index, chosen_rate, how_chosen);
                fails++;
            end
            else
            begin
                due = awaited_choices[0];
                awaited_choices.delete(0);
                case (due.how)
                    rvs_pkg::HOW_BEST:     by_score++;
                    rvs_pkg::HOW_FALLBACK: by_lowest++;
                    default:               by_none++;
                endcase
                if (chosen_index !== due.index)
                begin
                    $display("%0t: chosen_index expected %0d got %0d", $time, due.index,
                             chosen_index);
                    fails++;
                end
                if (chosen_rate !== due.rate)
                begin
                    $display("%0t: chosen_rate expected %0d got %0d", $time, due.rate,
                             chosen_rate);
                    fails++;
                end
                if (how_chosen !== due.how)
                begin
                    $display("%0t: how_chosen expected %0d got %0d", $time, due.how,
                             how_chosen);
                    fails++;
                end
            end
        end
    end

    task automatic push_word(input logic [rvs_pkg::RATE_W-1:0] est, input bit lim,
                             input bit vid, input bit pres, input int w, input int h,
                             input logic [rvs_pkg::RATE_W-1:0] rate, input bit last);
        word_t wd;
        wd = '{estimate: est, apply_limits: lim, is_video: vid, present: pres,
               variant_width: w[rvs_pkg::DIM_W-1:0], variant_height: h[rvs_pkg::DIM_W-1:0],
               variant_rate: rate, last_in_set: last};
        pending_words = {pending_words, wd};
        words_total++;
    endtask

    task automatic gen_set(input int len);
        logic [rvs_pkg::RATE_W-1:0] est;
        logic [rvs_pkg::RATE_W-1:0] rate;
        int                         w;
        int                         h;
        bit                         lim;
        bit                         vid;
        est = '0;
        rate = '0;
        w = 1920;
        h = 1080;
        case ($urandom_range(0, 5))
            0:       est = $urandom;
            4:       est = $urandom_range(0, 2000);
            5:       est = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
            default: est = $urandom_range(0, 50_000_000);
        endcase
        lim = ($urandom_range(0, 2) != 0);
        vid = ($urandom_range(0, 1) != 0);
        sets_total++;
        if (len > VARIANT_SLOTS)
            long_sets++;
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 4))
                0, 1: rate = $urandom_range(0, est / 10);
                2:    rate = $urandom_range(0, est);
                3:    rate = $urandom;
                default: ;
            endcase
            case ($urandom_range(0, 4))
                0:
                begin
                    w = $urandom_range(0, 16384);
                    h = $urandom_range(0, 16384);
                end
                1, 2:
                begin
                    w = 16 * $urandom_range(1, 1024);
                    h = 9 * w / 16;
                end
                3:
                begin
                    w = $urandom_range(0, 1) ? 16384 : 0;
                    h = $urandom_range(0, 1) ? 16383 : 1;
                end
                default: ;
            endcase
            if (i == 0)
                push_word(est, lim, vid, $urandom_range(0, 7) != 0, w, h, rate, i == len - 1);
            else
                push_word($urandom, $urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0,
                          $urandom_range(0, 7) != 0, w, h, rate, i == len - 1);
        end
    endtask

    task automatic run_phase(input int target);
        int start;
        start = words_total;
        while (words_total - start < target)
        begin
            if ($urandom_range(0, 59) == 0)
                gen_set($urandom_range(60, 70));
            else
                gen_set($urandom_range(1, 8));
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || in_valid || awaited_choices.size() != 0);
        repeat (80) @(negedge clk);
    endtask

    task automatic set_regs(input int w, input int h, input logic [rvs_pkg::RATE_W-1:0] lo,
                            input logic [rvs_pkg::RATE_W-1:0] hi);
        logic [rvs_pkg::CFG_IDX_W-1:0]  idx[4] = '{rvs_pkg::CFG_SCREEN_WIDTH,
                                                   rvs_pkg::CFG_SCREEN_HEIGHT,
                                                   rvs_pkg::CFG_RATE_FLOOR,
                                                   rvs_pkg::CFG_RATE_CEILING};
        logic [rvs_pkg::CFG_DATA_W-1:0] vals[4];
        vals = '{w, h, lo, hi};
        for (int i = 0; i < 4; i++)
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        scr_w = w[rvs_pkg::DIM_W-1:0];
        scr_h = h[rvs_pkg::DIM_W-1:0];
        floor_bps = lo;
        ceil_bps = hi;
        settings_used++;
        @(negedge clk);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset register values
        push_word(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, 16384, 16384, 32'd0, 1'b1);
        push_word(32'd1_000_000, 1'b1, 1'b1, 1'b1, 1920, 1080, 32'd900_000, 1'b0);
        push_word(32'd0, 1'b0, 1'b0, 1'b1, 16384, 16384, 32'd900_001, 1'b0);
        push_word(32'd0, 1'b0, 1'b0, 1'b1, 3840, 2160, 32'd500_000, 1'b0);
        push_word(32'd0, 1'b0, 1'b0, 1'b1, 0, 0, 32'd0, 1'b1);
        // nothing fits: lowest rate, earliest on a tie
        push_word(32'd10, 1'b1, 1'b0, 1'b1, 100, 100, 32'd5, 1'b0);
        push_word(32'd0, 1'b0, 1'b0, 1'b1, 100, 100, 32'd3, 1'b0);
        push_word(32'd0, 1'b0, 1'b0, 1'b1, 200, 200, 32'd3, 1'b1);
        // nothing present
        push_word(32'd0, 1'b0, 1'b0, 1'b0, 640, 480, 32'd0, 1'b0);
        push_word(32'd0, 1'b0, 1'b0, 1'b0, 640, 480, 32'd0, 1'b1);
        push_word(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 16384, 16384, 32'hFFFF_FFFF, 1'b1);
        // equal scores
        push_word(32'd5000, 1'b0, 1'b0, 1'b1, 640, 480, 32'd1000, 1'b0);
        push_word(32'd0, 1'b0, 1'b0, 1'b1, 640, 480, 32'd1000, 1'b1);
        push_word(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 16383, 1, 32'hFFFF_FFFF, 1'b0);
        push_word(32'd0, 1'b1, 1'b0, 1'b1, 1, 16383, 32'd3_865_470_565, 1'b1);
        push_word(32'd0, 1'b0, 1'b0, 1'b1, 0, 0, 32'd0, 1'b1);

        wait_drained();
        set_regs(1, 1, 32'hFFFF_FFFF, 32'd0);
        run_phase(PHASE_WORDS);

        // floor above ceiling
        wait_drained();
        set_regs(1920, 1080, 32'd5_000_000, 32'd1_000_000);
        run_phase(PHASE_WORDS);

        wait_drained();
        set_regs(16384, 16384, 32'd0, 32'hFFFF_FFFF);
        gen_set(70);
        run_phase(PHASE_WORDS - 70);

        wait_drained();
        set_regs($urandom_range(1, 16384), $urandom_range(1, 16384),
                 $urandom_range(0, 20_000_000),
                 $urandom_range(0, 1) ? 32'd0 : $urandom_range(1_000_000, 60_000_000));
        run_phase(PHASE_WORDS);

        wait_drained();
        set_regs($urandom_range(1, 4096), $urandom_range(1, 4096),
                 ($urandom_range(0, 3) == 0) ? $urandom : 32'd0, $urandom);
        run_phase(PHASE_WORDS);

        wait_drained();
        fails += awaited_choices.size();
        $display("Sent %0d words in %0d sets over %0d register settings, %0d sets past %0d slots.",
                 words_total, sets_total, settings_used, long_sets, VARIANT_SLOTS);
        $display("Choices: %0d by score, %0d by lowest rate, %0d empty; %0d mismatches.",
                 by_score, by_lowest, by_none, fails);
        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timed out with %0d words pending and %0d results outstanding.",
                 pending_words.size(), awaited_choices.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
